// ===== sv/sbq_pkg.sv =====
// ----------------------------------------------------------------------------
// sbq_pkg: shared types and constants for the stereo biquad
// Sample and coefficient formats, coefficient register indexes and the
// coefficient set that both channel filters share.
// ----------------------------------------------------------------------------
package sbq_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_BITS      = 18;
    localparam int COEF_FRAC_BITS = 14;
    localparam int NUM_COEFS      = 5;
    localparam int CFG_INDEX_BITS = $clog2(NUM_COEFS);

    // product is exact, five terms need three guard bits
    localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_BITS  = PROD_BITS + 3;
    localparam int RND_BITS  = ACC_BITS - COEF_FRAC_BITS;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;

    // coefficient register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_B0 = CFG_INDEX_BITS'(0),
        CFG_B1 = CFG_INDEX_BITS'(1),
        CFG_B2 = CFG_INDEX_BITS'(2),
        CFG_A1 = CFG_INDEX_BITS'(3),
        CFG_A2 = CFG_INDEX_BITS'(4)
    } cfg_index_t;

    typedef struct packed {
        coef_t b0;
        coef_t b1;
        coef_t b2;
        coef_t a1;
        coef_t a2;
    } coef_set_t;

    // unity gain in the coefficient format
    localparam coef_t COEF_UNITY = COEF_BITS'(1) << COEF_FRAC_BITS;

endpackage

// ===== sv/sbq_channel.sv =====
// ----------------------------------------------------------------------------
// sbq_channel: one channel of the direct form I biquad
// Holds the two-deep input and output history and computes the rounded,
// saturated output for the current sample in a single pass.
// ----------------------------------------------------------------------------
module sbq_channel
    import sbq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  coef_set_t coefs,
    input  sample_t   x,
    input  logic      advance,
    output sample_t   y
);

    sample_t x1_reg, x2_reg, y1_reg, y2_reg;

    logic signed [PROD_BITS-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
    logic signed [ACC_BITS-1:0]  acc;
    logic signed [RND_BITS-1:0]  rnd;
    logic [RND_BITS-SAMPLE_BITS:0] top_bits;

    always_comb
    begin
        p_b0 = PROD_BITS'(x) * PROD_BITS'(coefs.b0);
        p_b1 = PROD_BITS'(x1_reg) * PROD_BITS'(coefs.b1);
        p_b2 = PROD_BITS'(x2_reg) * PROD_BITS'(coefs.b2);
        p_a1 = PROD_BITS'(y1_reg) * PROD_BITS'(coefs.a1);
        p_a2 = PROD_BITS'(y2_reg) * PROD_BITS'(coefs.a2);
    end

    // round half up, then floor shift
    always_comb
    begin
        acc = ACC_BITS'(p_b0) + ACC_BITS'(p_b1) + ACC_BITS'(p_b2)
            - ACC_BITS'(p_a1) - ACC_BITS'(p_a2)
            + (ACC_BITS'(1) <<< (COEF_FRAC_BITS - 1));
        rnd = RND_BITS'(acc >>> COEF_FRAC_BITS);
    end

    // saturate when the bits above the sample sign disagree
    always_comb
    begin
        top_bits = rnd[RND_BITS-1:SAMPLE_BITS-1];
        if ((&top_bits) || !(|top_bits))
        begin
            y = rnd[SAMPLE_BITS-1:0];
        end
        else if (rnd[RND_BITS-1])
        begin
            y = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        else
        begin
            y = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg <= '0;
            x2_reg <= '0;
            y1_reg <= '0;
            y2_reg <= '0;
        end
        else if (advance)
        begin
            x2_reg <= x1_reg;
            x1_reg <= x;
            y2_reg <= y1_reg;
            y1_reg <= y;
        end
    end

endmodule

// ===== sv/stereo_biquad_direct_form_one.sv =====
// ----------------------------------------------------------------------------
// stereo_biquad_direct_form_one: stereo fixed-point biquad, direct form I
// Path: a sample pair taken into the input register is loaded into the result
//   register, which drives the outputs; the move waits while the output is
//   stalled.
// Throughput: one sample pair per cycle while the output is not stalled; the
//   loop that bounds it is each channel's output feedback through one
//   multiplier, the five-term sum and the saturation.
// Reset: history cleared to zero, b0 = 1.0, other coefficients zero.
// ----------------------------------------------------------------------------
module stereo_biquad_direct_form_one
    import sbq_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    // coefficient write port
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COEF_BITS-1:0]      cfg_data,

    // input sample stream
    input  logic                      in_valid,
    output logic                      in_stall,
    input  sample_t                   left_in,
    input  sample_t                   right_in,
    input  logic                      block_end,

    // output sample stream
    output logic                      out_valid,
    input  logic                      out_stall,
    output sample_t                   left_out,
    output sample_t                   right_out,
    output logic                      block_last
);

    // ------------------------------------------------------------------
    // coefficient registers, shared by both channels
    // ------------------------------------------------------------------
    coef_set_t coef_reg;
    coef_set_t coef_next;

    // writes are always taken; indexes past the last register are dropped
    assign cfg_ready = 1'b1;

    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_B0:  coef_next.b0 = cfg_data;
                CFG_B1:  coef_next.b1 = cfg_data;
                CFG_B2:  coef_next.b2 = cfg_data;
                CFG_A1:  coef_next.a1 = cfg_data;
                CFG_A2:  coef_next.a2 = cfg_data;
                default: coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.b0 <= COEF_UNITY;
            coef_reg.b1 <= '0;
            coef_reg.b2 <= '0;
            coef_reg.a1 <= '0;
            coef_reg.a2 <= '0;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    // ------------------------------------------------------------------
    // handshake control
    // the result register frees up when empty or when its transaction
    // completes this cycle; the input register then drains into it
    // ------------------------------------------------------------------
    logic    stage_full_reg, stage_full_next;
    logic    out_valid_reg, out_valid_next;
    logic    out_free;
    logic    advance;
    logic    accept;

    sample_t left_stage_reg, right_stage_reg;
    logic    last_stage_reg;
    sample_t left_out_reg, right_out_reg;
    logic    last_out_reg;
    sample_t left_y, right_y;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = stage_full_reg && out_free;
    assign in_stall = stage_full_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        stage_full_next = accept || (stage_full_reg && !out_free);
        priority if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_full_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            stage_full_reg <= stage_full_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // input register: captures each accepted transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            left_stage_reg  <= left_in;
            right_stage_reg <= right_in;
            last_stage_reg  <= block_end;
        end
    end

    // ------------------------------------------------------------------
    // filter datapath: one instance per channel, same coefficients
    // history advances exactly when a result enters the output register
    // ------------------------------------------------------------------
    sbq_channel u_left
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .coefs   (coef_reg),
        .x       (left_stage_reg),
        .advance (advance),
        .y       (left_y)
    );

    sbq_channel u_right
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .coefs   (coef_reg),
        .x       (right_stage_reg),
        .advance (advance),
        .y       (right_y)
    );

    // result register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            left_out_reg  <= left_y;
            right_out_reg <= right_y;
            last_out_reg  <= last_stage_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign left_out   = left_out_reg;
    assign right_out  = right_out_reg;
    assign block_last = last_out_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
    else $error("result register not loaded after advance");

    a_held_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_full_reg && !out_free) |=> (stage_full_reg && $stable(left_stage_reg)
            && $stable(right_stage_reg)))
    else $error("stalled input register lost its item");

    a_result_matches_filter: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (left_out_reg == $past(left_y)) && (right_out_reg == $past(right_y)))
    else $error("result register differs from filter output");

    a_bad_index_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && (cfg_index > CFG_A2)) |=> $stable(coef_reg))
    else $error("write to unused index changed a coefficient");

endmodule
